// ----- hdl/cbrp_pkg.sv -----
// ============================================================================
// cbrp_pkg
// Shared constants, types and helpers for the constant border row padder.
// ============================================================================
package cbrp_pkg;

    // Element and geometry limits.
    localparam int ELEM_BITS = 32;
    localparam int MAX_ROW   = 4096;
    localparam int MAX_PAD   = 31;

    // Fixed field widths.
    localparam int PIX_W = 32;
    localparam int ROW_W = 13;
    localparam int PAD_W = 5;
    localparam int IDX_W = 3;

    // Column counter and the width used to compare it against the row width.
    localparam int COL_W = $clog2(MAX_ROW);
    localparam int CMP_W = (COL_W + 1 > ROW_W) ? COL_W + 1 : ROW_W;

    // Pixels and the pad value keep only the element bits.
    localparam logic [PIX_W-1:0] ELEM_MASK =
        (ELEM_BITS >= PIX_W) ? {PIX_W{1'b1}} : PIX_W'((64'd1 << ELEM_BITS) - 64'd1);

    // Decoupling queue between front and back.
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_ROW_WIDTH = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_LEFT_PAD  = IDX_W'(1);
    localparam logic [IDX_W-1:0] REG_RIGHT_PAD = IDX_W'(2);
    localparam logic [IDX_W-1:0] REG_PAD_VALUE = IDX_W'(3);

    typedef struct packed {
        logic [ROW_W-1:0] row_width;
        logic [PAD_W-1:0] left_pad;
        logic [PAD_W-1:0] right_pad;
        logic [PIX_W-1:0] pad_value;
    } cfg_t;

    // One classified source pixel.
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             first;
        logic             last;
    } qent_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

    typedef enum logic [1:0] {
        ST_HEAD,
        ST_LEFT,
        ST_PIX,
        ST_RIGHT
    } bstate_t;

    function automatic logic [PAD_W-1:0] clamp_pad(input logic [PAD_W-1:0] p);
        clamp_pad = (32'(p) > MAX_PAD) ? PAD_W'(MAX_PAD) : p;
    endfunction

endpackage

// ----- hdl/cbrp_front.sv -----
// ============================================================================
// cbrp_front
// Accepts source pixels, tracks the column and tags row start and row end.
// ============================================================================
module cbrp_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [cbrp_pkg::PIX_W-1:0] pixel_in,
    input  logic [cbrp_pkg::ROW_W-1:0] row_width,
    input  cbrp_pkg::qstat_t           q_stat,
    output logic                       push,
    output cbrp_pkg::qent_t            push_data
);
    import cbrp_pkg::*;

    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [CMP_W-1:0] w_ext;
    logic [CMP_W-1:0] w_eff;
    logic [CMP_W-1:0] col_inc;
    logic             is_first;
    logic             is_last;

    // Clamp the row width to 1..MAX_ROW.
    always_comb
    begin
        w_ext = CMP_W'(row_width);
        if (w_ext == '0)
        begin
            w_eff = CMP_W'(1);
        end
        else if (w_ext > CMP_W'(MAX_ROW))
        begin
            w_eff = CMP_W'(MAX_ROW);
        end
        else
        begin
            w_eff = w_ext;
        end
        col_inc  = CMP_W'(col_reg) + CMP_W'(1);
        is_first = (col_reg == '0);
        // A width shrunk mid-row ends the row at once.
        is_last  = (col_inc >= w_eff);
    end

    assign in_ready = !q_stat.full;
    assign push     = in_valid && in_ready;

    always_comb
    begin
        push_data.pixel = pixel_in;
        push_data.first = is_first;
        push_data.last  = is_last;
        col_next        = col_reg;
        if (push)
        begin
            col_next = is_last ? '0 : col_inc[COL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
        end
    end

endmodule

// ----- hdl/cbrp_queue.sv -----
// ============================================================================
// cbrp_queue
// Short FIFO of classified pixels between the front and the back.
// ============================================================================
module cbrp_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  cbrp_pkg::qent_t  push_data,
    input  logic             pop,
    output cbrp_pkg::qent_t  head,
    output cbrp_pkg::qstat_t stat
);
    import cbrp_pkg::*;

    qent_t            mem_reg [Q_DEPTH];
    logic [Q_AW-1:0]  wr_ptr_reg;
    logic [Q_AW-1:0]  wr_ptr_next;
    logic [Q_AW-1:0]  rd_ptr_reg;
    logic [Q_AW-1:0]  rd_ptr_next;
    logic [Q_CW-1:0]  cnt_reg;
    logic [Q_CW-1:0]  cnt_next;

    function automatic logic [Q_AW-1:0] ptr_inc(input logic [Q_AW-1:0] p);
        ptr_inc = (32'(p) == Q_DEPTH - 1) ? '0 : p + Q_AW'(1);
    endfunction

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        cnt_next    = cnt_reg + Q_CW'(push) - Q_CW'(pop);
    end

    assign head       = mem_reg[rd_ptr_reg];
    assign stat.full  = (cnt_reg == Q_CW'(Q_DEPTH));
    assign stat.empty = (cnt_reg == '0);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ----- hdl/cbrp_back.sv -----
// ============================================================================
// cbrp_back
// Emits queued pixels, with left pads before a row and right pads after it.
// ============================================================================
module cbrp_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  cbrp_pkg::cfg_t             cfg,
    input  cbrp_pkg::qstat_t           q_stat,
    input  cbrp_pkg::qent_t            head,
    output logic                       pop,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [cbrp_pkg::PIX_W-1:0] pixel_out,
    output logic                       run_last,
    output logic                       row_end
);
    import cbrp_pkg::*;

    bstate_t          state_reg;
    bstate_t          state_next;
    logic [PAD_W-1:0] rem_reg;
    logic [PAD_W-1:0] rem_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [PIX_W-1:0] pix_reg;
    logic             last_reg;
    logic             end_reg;

    logic [PAD_W-1:0] lp;
    logic [PAD_W-1:0] rp;
    logic [PIX_W-1:0] pad_px;
    logic             go;
    logic             pop_int;
    logic [PIX_W-1:0] emit_px;
    logic             emit_last;
    logic             emit_end;

    assign lp     = clamp_pad(cfg.left_pad);
    assign rp     = clamp_pad(cfg.right_pad);
    assign pad_px = cfg.pad_value & ELEM_MASK;
    // Output register loads if empty or being drained and the queue is not.
    assign go     = (!out_valid_reg || out_ready) && !q_stat.empty;

    always_comb
    begin
        state_next = state_reg;
        rem_next   = rem_reg;
        pop_int    = 1'b0;
        emit_px    = pad_px;
        emit_last  = 1'b0;
        emit_end   = 1'b0;
        if (go)
        begin
            unique case (state_reg) inside
                ST_HEAD, ST_PIX:
                begin
                    if (state_reg == ST_HEAD && head.first && lp != '0)
                    begin
                        rem_next   = lp - PAD_W'(1);
                        state_next = (lp == PAD_W'(1)) ? ST_PIX : ST_LEFT;
                    end
                    else
                    begin
                        emit_px   = head.pixel & ELEM_MASK;
                        emit_last = !(head.last && rp != '0);
                        emit_end  = head.last && rp == '0;
                        if (head.last && rp != '0)
                        begin
                            rem_next   = rp;
                            state_next = ST_RIGHT;
                        end
                        else
                        begin
                            pop_int    = 1'b1;
                            state_next = ST_HEAD;
                        end
                    end
                end
                ST_LEFT:
                begin
                    rem_next = rem_reg - PAD_W'(1);
                    if (rem_reg == PAD_W'(1))
                    begin
                        state_next = ST_PIX;
                    end
                end
                ST_RIGHT:
                begin
                    rem_next  = rem_reg - PAD_W'(1);
                    emit_last = (rem_reg == PAD_W'(1));
                    emit_end  = (rem_reg == PAD_W'(1));
                    if (rem_reg == PAD_W'(1))
                    begin
                        pop_int    = 1'b1;
                        state_next = ST_HEAD;
                    end
                end
                default:
                begin
                    state_next = ST_HEAD;
                end
            endcase
        end
        out_valid_next = go ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    assign pop       = pop_int;
    assign out_valid = out_valid_reg;
    assign pixel_out = pix_reg;
    assign run_last  = last_reg;
    assign row_end   = end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_HEAD;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            pix_reg  <= emit_px;
            last_reg <= emit_last;
            end_reg  <= emit_end;
        end
    end

endmodule

// ----- hdl/constant_border_row_padder_core.sv -----
// ============================================================================
// constant_border_row_padder_core
// Constant border padding of a raster pixel stream, one row at a time.
// ============================================================================
//
// Channel   Direction  Handshake              Payload
// ------    ---------  ---------------------  --------------------------------
// in        sink       in_valid / in_ready    pixel_in[31:0]
// out       source     out_valid / out_ready  pixel_out[31:0], run_last, row_end
// cfg       sink       cfg_valid / cfg_ready  cfg_index[2:0], cfg_data[31:0]
//
// Each output transaction moves one pixel; the output register sustains one
// transaction per cycle while out_ready holds and the queue is not empty.
// A row's first pixel is preceded by left_pad pads and its last pixel followed
// by right_pad pads; the back-end sequencer emits one result per unstalled cycle.
// A two-entry queue lets the input side keep accepting while pads are emitted.
// Reset clears the column counter, the queue and the configuration
// registers (row width 1, no pads, pad value 0); no clearing pass is needed.
// The configuration port is always ready; writes to unknown indexes are dropped.
//
module constant_border_row_padder_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [cbrp_pkg::PIX_W-1:0] pixel_in,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [cbrp_pkg::PIX_W-1:0] pixel_out,
    output logic                       run_last,
    output logic                       row_end,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [cbrp_pkg::IDX_W-1:0] cfg_index,
    input  logic [cbrp_pkg::PIX_W-1:0] cfg_data
);
    import cbrp_pkg::*;

    // Configuration registers, held as one struct for the front and back.
    cfg_t   cfg_reg;
    cfg_t   cfg_next;

    // Front to queue.
    logic   push;
    qent_t  push_data;

    // Queue to back.
    qent_t  head;
    qstat_t q_stat;
    logic   pop;

    // The configuration port never stalls.
    assign cfg_ready = 1'b1;

    // Register write decode. The upper data bits beyond each field are
    // discarded, matching the field widths.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_ROW_WIDTH: cfg_next.row_width = cfg_data[ROW_W-1:0];
                REG_LEFT_PAD:  cfg_next.left_pad  = cfg_data[PAD_W-1:0];
                REG_RIGHT_PAD: cfg_next.right_pad = cfg_data[PAD_W-1:0];
                REG_PAD_VALUE: cfg_next.pad_value = cfg_data;
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.row_width <= ROW_W'(1);
            cfg_reg.left_pad  <= '0;
            cfg_reg.right_pad <= '0;
            cfg_reg.pad_value <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // The front classifies each accepted pixel as row start and/or row end.
    cbrp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .pixel_in  (pixel_in),
        .row_width (cfg_reg.row_width),
        .q_stat    (q_stat),
        .push      (push),
        .push_data (push_data)
    );

    // The queue decouples the input stall from the pad runs at the back.
    cbrp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .stat      (q_stat)
    );

    // The back walks each entry through its left pads, pixel and right pads.
    cbrp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_stat    (q_stat),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .pixel_out (pixel_out),
        .run_last  (run_last),
        .row_end   (row_end)
    );

    // The end of a padded row is always the last result of its input pixel.
    a_row_end_is_run_last: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && row_end) |-> run_last
    ) else $error("row_end without run_last");

    // The back never retires an entry from an empty queue.
    a_pop_not_empty: assert property (
        @(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty
    ) else $error("queue pop while empty");

    // A result only appears after the queue held an entry.
    a_out_from_queue: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!q_stat.empty)
    ) else $error("output valid without a queued pixel");

endmodule
